[hw/rtl/baro_temp_pressure_compensate_defines.svh]
// assertion macros for the barometric compensation block
// expects clk and rst_n in the scope where a macro is used
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_DEFINES_SVH

// checked only while out of reset
`define BTPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BTPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/btpc_pkg.sv]
// types and constants of the barometric compensation block
// no dependencies
package btpc_pkg;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [17:0]        pressure_centi_mbar;
    logic               clipped;
  } out_item_t;

  // register indexes on the config port
  localparam logic [2:0] REG_SENS      = 3'd0;
  localparam logic [2:0] REG_OFFSET    = 3'd1;
  localparam logic [2:0] REG_SENS_TC   = 3'd2;
  localparam logic [2:0] REG_OFFSET_TC = 3'd3;
  localparam logic [2:0] REG_REF_TEMP  = 3'd4;
  localparam logic [2:0] REG_TEMP_TC   = 3'd5;
  localparam logic [2:0] REG_SO_EN     = 3'd6;

  localparam int PIPE_DEPTH = 9;

  // internal widths
  localparam int DT_W   = 25;
  localparam int TEMP_W = 20;
  localparam int OFF_W  = 42;
  localparam int SENS_W = 40;
  localparam int P_W    = 49;

  localparam logic signed [TEMP_W-1:0] TEMP_REF     = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD    = -20'sd1500;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW     = -20'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH    = 20'sd8500;
  localparam logic signed [P_W-1:0]    PRES_LOW     = 49'sd1000;
  localparam logic signed [P_W-1:0]    PRES_HIGH    = 49'sd200000;

endpackage

[hw/rtl/baro_temp_pressure_compensate.sv]
// barometric sensor compensation: raw D1/D2 in, 0.01 degC and 0.01 mbar out
// the out_valid strobe follows the start transfer through the stage registers; one item per cycle,
// busy never rises, since every stage is a plain register and the receiver cannot stall
// synchronous active-low reset clears the stage valid bits and loads the register
// defaults (all calibration words 0, second-order corrections on)
// depends on btpc_pkg and baro_temp_pressure_compensate_defines.svh
`include "baro_temp_pressure_compensate_defines.svh"

module baro_temp_pressure_compensate (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  btpc_pkg::in_item_t   in_data,
  // result channel
  output logic                 out_valid,
  output btpc_pkg::out_item_t  out_data,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import btpc_pkg::*;

  // ---------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------
  logic [15:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic        so_en_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
      c4_r    <= '0;
      c5_r    <= '0;
      c6_r    <= '0;
      so_en_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SENS:      c1_r    <= pwdata[15:0];
        REG_OFFSET:    c2_r    <= pwdata[15:0];
        REG_SENS_TC:   c3_r    <= pwdata[15:0];
        REG_OFFSET_TC: c4_r    <= pwdata[15:0];
        REG_REF_TEMP:  c5_r    <= pwdata[15:0];
        REG_TEMP_TC:   c6_r    <= pwdata[15:0];
        REG_SO_EN:     so_en_r <= pwdata[0];
        default: ;     // writes past the last register are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SENS:      prdata = {16'b0, c1_r};
      REG_OFFSET:    prdata = {16'b0, c2_r};
      REG_SENS_TC:   prdata = {16'b0, c3_r};
      REG_OFFSET_TC: prdata = {16'b0, c4_r};
      REG_REF_TEMP:  prdata = {16'b0, c5_r};
      REG_TEMP_TC:   prdata = {16'b0, c6_r};
      REG_SO_EN:     prdata = {31'b0, so_en_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // valid bits travel alongside the stage registers
  // ---------------------------------------------------------------------
  logic                  in_xfer;
  logic [PIPE_DEPTH-1:0] vld_r;

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_xfer};
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

  // ---------------------------------------------------------------------
  // stage 1: dT = D2 - C5*2^8
  // ---------------------------------------------------------------------
  logic signed [DT_W-1:0] dt1_nxt, dt1_r;
  logic [23:0]            d1_1_r;

  assign dt1_nxt = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, c5_r, 8'b0});

  always_ff @(posedge clk) begin
    dt1_r  <= dt1_nxt;
    d1_1_r <= in_data.raw_pressure;
  end

  // ---------------------------------------------------------------------
  // stage 2: the four products on dT (one multiplier each)
  // ---------------------------------------------------------------------
  logic signed [41:0] p6_2_r, p4_2_r, p3_2_r;
  logic signed [49:0] dsq_full;
  logic [47:0]        dsq_2_r;
  logic [23:0]        d1_2_r;

  assign dsq_full = 50'(dt1_r) * 50'(dt1_r);

  always_ff @(posedge clk) begin
    p6_2_r  <= 42'(dt1_r) * 42'($signed({1'b0, c6_r}));
    p4_2_r  <= 42'(dt1_r) * 42'($signed({1'b0, c4_r}));
    p3_2_r  <= 42'(dt1_r) * 42'($signed({1'b0, c3_r}));
    dsq_2_r <= dsq_full[47:0];   // dT^2 is never negative and stays below 2^48
    d1_2_r  <= d1_1_r;
  end

  // ---------------------------------------------------------------------
  // stage 3: TEMP, OFF, SENS and the T2 term
  // ---------------------------------------------------------------------
  logic signed [TEMP_W-1:0] temp3_nxt, temp3_r;
  logic signed [OFF_W-1:0]  off3_nxt, off3_r;
  logic signed [SENS_W-1:0] sens3_nxt, sens3_r;
  logic [49:0]              dsq_x3;
  logic [50:0]              dsq_x5;
  logic [16:0]              t2_nxt, t2_3_r;
  logic [23:0]              d1_3_r;

  assign temp3_nxt = TEMP_REF + TEMP_W'(p6_2_r >>> 23);
  assign off3_nxt  = OFF_W'($signed({1'b0, c2_r, 17'b0})) + OFF_W'(p4_2_r >>> 6);
  assign sens3_nxt = SENS_W'($signed({1'b0, c1_r, 16'b0})) + SENS_W'(p3_2_r >>> 7);

  assign dsq_x3 = 50'(dsq_2_r) + (50'(dsq_2_r) << 1);
  assign dsq_x5 = 51'(dsq_2_r) + (51'(dsq_2_r) << 2);

  always_comb begin
    if (!so_en_r) begin
      t2_nxt = '0;
    end else if (temp3_nxt < TEMP_REF) begin
      t2_nxt = 17'(dsq_x3 >> 33);
    end else begin
      t2_nxt = 17'(dsq_x5 >> 38);
    end
  end

  always_ff @(posedge clk) begin
    temp3_r <= temp3_nxt;
    off3_r  <= off3_nxt;
    sens3_r <= sens3_nxt;
    t2_3_r  <= t2_nxt;
    d1_3_r  <= d1_2_r;
  end

  // ---------------------------------------------------------------------
  // stage 4: squares of (TEMP-2000) and (TEMP+1500), final temperature
  // ---------------------------------------------------------------------
  logic signed [TEMP_W-1:0]   a_dev, b_dev, tempf_nxt, tempf4_r;
  logic signed [2*TEMP_W-1:0] asq_full, bsq_full;
  logic [34:0]                asq4_r, bsq4_r;
  logic                       use_a4_r, use_b4_r;
  logic signed [OFF_W-1:0]    off4_r;
  logic signed [SENS_W-1:0]   sens4_r;
  logic [23:0]                d1_4_r;

  assign a_dev     = temp3_r - TEMP_REF;
  assign b_dev     = temp3_r - TEMP_COLD;
  assign asq_full  = (2*TEMP_W)'(a_dev) * (2*TEMP_W)'(a_dev);
  assign bsq_full  = (2*TEMP_W)'(b_dev) * (2*TEMP_W)'(b_dev);
  assign tempf_nxt = temp3_r - $signed({3'b0, t2_3_r});

  always_ff @(posedge clk) begin
    asq4_r   <= asq_full[34:0];
    bsq4_r   <= bsq_full[34:0];
    // corrections are picked on TEMP before T2 comes off
    use_a4_r <= so_en_r & (temp3_r < TEMP_REF);
    use_b4_r <= so_en_r & (temp3_r < TEMP_COLD);
    tempf4_r <= tempf_nxt;
    off4_r   <= off3_r;
    sens4_r  <= sens3_r;
    d1_4_r   <= d1_3_r;
  end

  // ---------------------------------------------------------------------
  // stage 5: OFF2 and SENS2 by shift-add, temperature saturation
  // ---------------------------------------------------------------------
  logic [40:0]               off2_a, off2_b, off2_nxt, off2_5_r;
  logic [39:0]               sens2_a, sens2_b, sens2_nxt, sens2_5_r;
  logic signed [TEMP_W-1:0]  tempc_nxt, tempc5_r;
  logic                      clip_t_nxt, clip_t5_r;
  logic signed [OFF_W-1:0]   off5_r;
  logic signed [SENS_W-1:0]  sens5_r;
  logic [23:0]               d1_5_r;

  // 61 = 64 - 4 + 1, 29 = 32 - 4 + 1, 17 = 16 + 1, 9 = 8 + 1
  assign off2_a  = use_a4_r ?
                   (((41'(asq4_r) << 6) - (41'(asq4_r) << 2) + 41'(asq4_r)) >> 4) : '0;
  assign off2_b  = use_b4_r ? ((41'(bsq4_r) << 4) + 41'(bsq4_r)) : '0;
  assign sens2_a = use_a4_r ?
                   (((40'(asq4_r) << 5) - (40'(asq4_r) << 2) + 40'(asq4_r)) >> 4) : '0;
  assign sens2_b = use_b4_r ? ((40'(bsq4_r) << 3) + 40'(bsq4_r)) : '0;
  assign off2_nxt  = off2_a + off2_b;
  assign sens2_nxt = sens2_a + sens2_b;

  always_comb begin
    clip_t_nxt = 1'b0;
    tempc_nxt  = tempf4_r;
    if (tempf4_r < TEMP_LOW) begin
      tempc_nxt  = TEMP_LOW;
      clip_t_nxt = 1'b1;
    end else if (tempf4_r > TEMP_HIGH) begin
      tempc_nxt  = TEMP_HIGH;
      clip_t_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    off2_5_r  <= off2_nxt;
    sens2_5_r <= sens2_nxt;
    tempc5_r  <= tempc_nxt;
    clip_t5_r <= clip_t_nxt;
    off5_r    <= off4_r;
    sens5_r   <= sens4_r;
    d1_5_r    <= d1_4_r;
  end

  // ---------------------------------------------------------------------
  // stage 6: corrected OFF and SENS
  // ---------------------------------------------------------------------
  logic signed [OFF_W-1:0]  offf6_r;
  logic signed [SENS_W-1:0] sensf6_r;
  logic signed [TEMP_W-1:0] tempc6_r;
  logic                     clip_t6_r;
  logic [23:0]              d1_6_r;

  always_ff @(posedge clk) begin
    offf6_r   <= off5_r - $signed({1'b0, off2_5_r});
    sensf6_r  <= sens5_r - $signed({1'b0, sens2_5_r[SENS_W-2:0]});
    tempc6_r  <= tempc5_r;
    clip_t6_r <= clip_t5_r;
    d1_6_r    <= d1_5_r;
  end

  // ---------------------------------------------------------------------
  // stage 7: D1 * SENS as two partial products (low 20 bits, signed high part)
  // ---------------------------------------------------------------------
  logic [43:0]              pp_lo7_r;
  logic signed [44:0]       pp_hi7_r;
  logic signed [OFF_W-1:0]  off7_r;
  logic signed [TEMP_W-1:0] tempc7_r;
  logic                     clip_t7_r;

  always_ff @(posedge clk) begin
    pp_lo7_r  <= 44'(d1_6_r) * 44'(sensf6_r[19:0]);
    pp_hi7_r  <= 45'($signed({1'b0, d1_6_r})) * 45'($signed(sensf6_r[SENS_W-1:20]));
    off7_r    <= offf6_r;
    tempc7_r  <= tempc6_r;
    clip_t7_r <= clip_t6_r;
  end

  // ---------------------------------------------------------------------
  // stage 8: recombine the partial products
  // ---------------------------------------------------------------------
  logic signed [63:0]       prod8_r;
  logic signed [OFF_W-1:0]  off8_r;
  logic signed [TEMP_W-1:0] tempc8_r;
  logic                     clip_t8_r;

  always_ff @(posedge clk) begin
    prod8_r   <= (64'(pp_hi7_r) <<< 20) + $signed({20'b0, pp_lo7_r});
    off8_r    <= off7_r;
    tempc8_r  <= tempc7_r;
    clip_t8_r <= clip_t7_r;
  end

  // ---------------------------------------------------------------------
  // stage 9: P = ((D1*SENS >> 21) - OFF) >> 15, saturate, output register
  // ---------------------------------------------------------------------
  logic signed [63:0]    q_diff;
  logic signed [P_W-1:0] p_raw, p_sat;
  logic                  clip_p;

  assign q_diff = (prod8_r >>> 21) - 64'(off8_r);
  assign p_raw  = P_W'(q_diff >>> 15);

  always_comb begin
    clip_p = 1'b0;
    p_sat  = p_raw;
    if (p_raw < PRES_LOW) begin
      p_sat  = PRES_LOW;
      clip_p = 1'b1;
    end else if (p_raw > PRES_HIGH) begin
      p_sat  = PRES_HIGH;
      clip_p = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_data.temperature_centi   <= 15'(tempc8_r);
    out_data.pressure_centi_mbar <= 18'(p_sat);
    out_data.clipped             <= clip_t8_r | clip_p;
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `BTPC_ASSERT(a_latency, in_xfer |-> ##PIPE_DEPTH out_valid, "result strobe missing after start")
  `BTPC_ASSERT(a_temp_range, out_valid |-> (out_data.temperature_centi >= -15'sd4000 && out_data.temperature_centi <= 15'sd8500), "temperature out of range")
  `BTPC_ASSERT(a_pres_range, out_valid |-> (out_data.pressure_centi_mbar >= 18'd1000 && out_data.pressure_centi_mbar <= 18'd200000), "pressure out of range")
  `BTPC_ASSERT(a_clip_bound, (out_valid && out_data.clipped) |-> (out_data.temperature_centi == -15'sd4000 || out_data.temperature_centi == 15'sd8500 || out_data.pressure_centi_mbar == 18'd1000 || out_data.pressure_centi_mbar == 18'd200000), "clip flag without a saturated value")
  `BTPC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule

[sim/baro_temp_pressure_compensate_tb.sv]
// testbench for baro_temp_pressure_compensate: a directed table, then random phases
// under changing calibration, each reading checked against typed-in values or a built-in model
// depends on btpc_pkg and the rtl of the block
`timescale 1ns / 100ps

module baro_temp_pressure_compensate_tb;
  import btpc_pkg::*;

  // unmapped register slot, just past the last calibration register
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  // compensation constants in 0.01 degC or 0.01 mbar, plus the largest raw reading
  localparam longint T_NOMINAL   = 2000;
  localparam longint T_COLD_EDGE = -1500;
  localparam longint T_FLOOR     = -4000;
  localparam longint T_CEIL      = 8500;
  localparam longint P_FLOOR     = 1000;
  localparam longint P_CEIL      = 200000;
  localparam longint RAW_MAX     = 64'hFFFFFF;

  // raw temperature that gives dT = 0 with the typical calibration (C5 = 31553)
  localparam int REF_D2 = 31553 * 256;

  localparam int N_DIRECTED      = 22;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int WATCHDOG_LIMIT  = 2000;

  // calibration loaded before a directed row
  typedef enum int {
    CAL_KEEP,
    CAL_TYPICAL,
    CAL_FIRST_ORDER,
    CAL_MAX,
    CAL_ZERO
  } cal_set_t;

  typedef struct {
    cal_set_t    cal;
    logic [23:0] d1;
    logic [23:0] d2;
    bit          typed;
    out_item_t   res;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the calibration registers, reset values
  logic [15:0] cal_word [6] = '{default: 16'd0};
  logic        cal_second_order = 1'b1;

  out_item_t   pending_readings [$];
  int          mismatches = 0;
  int          sender_gap_pct = 0;
  int          quiet_cycles = 0;

  // directed rows: reset defaults, typical part across every temperature branch,
  // first-order only, all words at max, all words at zero.
  // expected readings are typed in only for the trivial calibrations
  stim_row_t directed_rows [N_DIRECTED] = '{
    // reset defaults: sens and off are zero, so pressure collapses to the floor
    '{CAL_KEEP, 24'h000000, 24'h000000, 1'b1, '{15'sd2000, 18'd1000, 1'b1}},
    // large dT at the warm side pulls T2 = 5119 off the temperature
    '{CAL_KEEP, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{-15'sd3119, 18'd1000, 1'b1}},
    // typical part: nominal reading, then pressure extremes
    '{CAL_TYPICAL, 24'd6465444, 24'd8077636, 1'b0, '0},
    '{CAL_KEEP, 24'h000000, 24'd8077636, 1'b0, '0},   // negative intermediate pressure
    '{CAL_KEEP, 24'hFFFFFF, 24'd8077636, 1'b0, '0},   // pressure above range
    '{CAL_KEEP, 24'd6465444, 24'h000000, 1'b0, '0},   // deep cold, temperature floor
    '{CAL_KEEP, 24'd6465444, 24'hFFFFFF, 1'b0, '0},   // hot, temperature ceiling
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 - 1500000), 1'b0, '0}, // below -15 degC
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 - 600000), 1'b0, '0},  // cold, above -15 degC
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 + 1800000), 1'b0, '0},
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 + 2000000), 1'b0, '0}, // just over the ceiling
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2), 1'b0, '0},           // exactly 20 degC
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 - 1), 1'b0, '0},       // one step under 20 degC
    // second-order corrections off, plus a write to an unmapped slot
    '{CAL_FIRST_ORDER, 24'd6465444, 24'(REF_D2 - 1500000), 1'b0, '0},
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 - 600000), 1'b0, '0},
    '{CAL_KEEP, 24'd6465444, 24'(REF_D2 - 1), 1'b0, '0},
    // every calibration word at its maximum
    '{CAL_MAX, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{CAL_KEEP, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{CAL_KEEP, 24'h000000, 24'hFFFFFF, 1'b0, '0},
    '{CAL_KEEP, 24'h800000, 24'hFFFF00, 1'b0, '0},
    // every word zero, corrections off: fixed 20 degC and pressure floor
    '{CAL_ZERO, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{15'sd2000, 18'd1000, 1'b1}},
    '{CAL_KEEP, 24'h000000, 24'h000000, 1'b1, '{15'sd2000, 18'd1000, 1'b1}}
  };

  baro_temp_pressure_compensate i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // integer compensation with floor shifts; every intermediate fits in 64 bits
  function automatic out_item_t compensate(input in_item_t it);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, t, off, sens, t2, off2, sens2, a, b, p;
    bit hit;
    out_item_t r;
    d1 = it.raw_pressure;
    d2 = it.raw_temperature;
    c1 = cal_word[REG_SENS];
    c2 = cal_word[REG_OFFSET];
    c3 = cal_word[REG_SENS_TC];
    c4 = cal_word[REG_OFFSET_TC];
    c5 = cal_word[REG_REF_TEMP];
    c6 = cal_word[REG_TEMP_TC];
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    hit = 1'b0;

    dt   = d2 - c5 * 256;
    t    = T_NOMINAL + ((dt * c6) >>> 23);
    off  = c2 * 131072 + ((c4 * dt) >>> 6);
    sens = c1 * 65536 + ((c3 * dt) >>> 7);

    // branch on the first-order temperature, before T2 comes off
    if (cal_second_order) begin
      if (t < T_NOMINAL) begin
        a     = t - T_NOMINAL;
        t2    = (3 * dt * dt) >>> 33;
        off2  = (61 * a * a) >>> 4;
        sens2 = (29 * a * a) >>> 4;
        if (t < T_COLD_EDGE) begin
          b     = t - T_COLD_EDGE;
          off2  = off2 + 17 * b * b;
          sens2 = sens2 + 9 * b * b;
        end
      end else begin
        t2 = (5 * dt * dt) >>> 38;
      end
    end

    t    = t - t2;
    off  = off - off2;
    sens = sens - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;

    // each value saturates on its own, either one sets the clip flag
    if (t < T_FLOOR) begin
      t = T_FLOOR;
      hit = 1'b1;
    end else if (t > T_CEIL) begin
      t = T_CEIL;
      hit = 1'b1;
    end
    if (p < P_FLOOR) begin
      p = P_FLOOR;
      hit = 1'b1;
    end else if (p > P_CEIL) begin
      p = P_CEIL;
      hit = 1'b1;
    end

    r.temperature_centi   = t[14:0];
    r.pressure_centi_mbar = p[17:0];
    r.clipped             = hit;
    return r;
  endfunction

  // one register write: setup cycle, access cycle, then an idle cycle.
  // bits above the register width carry junk, the block must drop them
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    logic [31:0] wdata;
    wdata = $urandom();
    if (idx == REG_SO_EN) wdata[0] = value[0];
    else wdata[15:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx) inside
      REG_SO_EN: cal_second_order = wdata[0];
      REG_SENS, REG_OFFSET, REG_SENS_TC, REG_OFFSET_TC, REG_REF_TEMP, REG_TEMP_TC: begin
        cal_word[idx] = wdata[15:0];
      end
      default: ;  // unmapped slot, write is dropped
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_calibration(input logic [15:0] c1, c2, c3, c4, c5, c6,
                                   input logic so_on);
    write_reg(REG_SENS, c1);
    write_reg(REG_OFFSET, c2);
    write_reg(REG_SENS_TC, c3);
    write_reg(REG_OFFSET_TC, c4);
    write_reg(REG_REF_TEMP, c5);
    write_reg(REG_TEMP_TC, c6);
    write_reg(REG_SO_EN, {15'd0, so_on});
  endtask

  task automatic load_cal_set(input cal_set_t sel);
    case (sel)
      CAL_TYPICAL: begin
        write_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165,
                          1'b1);
      end
      CAL_FIRST_ORDER: begin
        write_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165,
                          1'b0);
        write_reg(REG_UNMAPPED, 16'hFFFF);
      end
      CAL_MAX: write_calibration('1, '1, '1, '1, '1, '1, 1'b1);
      CAL_ZERO: write_calibration('0, '0, '0, '0, '0, '0, 1'b0);
      default: ;
    endcase
  endtask

  // calibration word, weighted toward both extremes
  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // most raw temperatures land near the reference point, at spreads from a few
  // counts to the full range, so every temperature branch gets traffic
  function automatic in_item_t random_item();
    in_item_t it;
    longint d2v, span;
    int sh;
    it.raw_pressure = 24'($urandom());
    if ($urandom_range(0, 3) == 0) begin
      it.raw_temperature = 24'($urandom());
    end else begin
      sh   = $urandom_range(4, 23);
      span = longint'($urandom_range(0, (1 << sh) - 1));
      d2v  = longint'(cal_word[REG_REF_TEMP]) * 256;
      d2v  = ($urandom_range(0, 1) == 1) ? d2v + span : d2v - span;
      if (d2v < 0) d2v = 0;
      else if (d2v > RAW_MAX) d2v = RAW_MAX;
      it.raw_temperature = d2v[23:0];
    end
    return it;
  endfunction

  // present one sample pair, with random gaps before it, and hold it until the
  // transfer; entered and left at a falling edge
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t want;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    want = typed ? typed_res : compensate(it);
    pending_readings = {pending_readings, want};
    @(negedge clk);
  endtask

  // block goes idle once every reading is back; the task waits spare cycles on top
  task automatic wait_for_readings();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: the block cannot be held off, so every strobe is a transfer
  always @(posedge clk) begin : reading_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_readings.size() == 0) begin
        $error("reading with none pending: temperature_centi %0d pressure_centi_mbar %0d",
               out_data.temperature_centi, out_data.pressure_centi_mbar);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (out_data.temperature_centi !== want.temperature_centi) begin
          $error("temperature_centi expected %0d actual %0d",
                 want.temperature_centi, out_data.temperature_centi);
          mismatches++;
        end
        if (out_data.pressure_centi_mbar !== want.pressure_centi_mbar) begin
          $error("pressure_centi_mbar expected %0d actual %0d",
                 want.pressure_centi_mbar, out_data.pressure_centi_mbar);
          mismatches++;
        end
        if (out_data.clipped !== want.clipped) begin
          $error("clipped expected %0d actual %0d", want.clipped, out_data.clipped);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any transfer on any port restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // reset held from the start, released once
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, sender flat out
    sender_gap_pct = 0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].cal != CAL_KEEP) begin
        wait_for_readings();
        load_cal_set(directed_rows[i].cal);
      end
      send_item({directed_rows[i].d1, directed_rows[i].d2}, directed_rows[i].typed,
                directed_rows[i].res);
    end

    // random phases, each with fresh calibration and a gap pattern set by the phase number
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_for_readings();
      write_calibration(random_word(), random_word(), random_word(), random_word(),
                        random_word(), random_word(), 1'($urandom_range(0, 1)));
      case (ph % 4)
        1: sender_gap_pct = 68;
        3: sender_gap_pct = 13;
        // the receiver cannot stall, so its phase also runs the sender flat out
        default: sender_gap_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item(), 1'b0, '0);
      end
    end

    wait_for_readings();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
